/* hdl/work_break_countdown_timer_defines.svh */
// Assertion helpers shared by the checker file.
`ifndef WORK_BREAK_COUNTDOWN_TIMER_DEFINES_SVH
`define WORK_BREAK_COUNTDOWN_TIMER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WBCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wbct check failed");

// Next-cycle implication, disabled during reset.
`define WBCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wbct check failed");

`endif

/* hdl/wbct_pkg.sv */
package wbct_pkg;

  localparam int CFG_DW = 6;
  localparam int CFG_IW = 3;

  localparam logic [CFG_IW-1:0] CFG_DEF_WORK  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_DEF_BREAK = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_WORK_MAX  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WORK_MIN  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_BREAK_MAX = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_BREAK_MIN = 3'd5;

  localparam logic [5:0] RST_DEF_WORK  = 6'd25;
  localparam logic [4:0] RST_DEF_BREAK = 5'd5;
  localparam logic [5:0] RST_WORK_MAX  = 6'd60;
  localparam logic [5:0] RST_WORK_MIN  = 6'd1;
  localparam logic [4:0] RST_BREAK_MAX = 5'd20;
  localparam logic [4:0] RST_BREAK_MIN = 5'd1;

  localparam logic [3:0] CODE_SETUP = 4'hC;
  localparam logic [3:0] CODE_WORK  = 4'hF;
  localparam logic [3:0] CODE_BREAK = 4'hB;

  localparam logic [15:0] LEDS_SETUP_WORK  = 16'b1111010000000000;
  localparam logic [15:0] LEDS_SETUP_BREAK = 16'b1111011000000000;
  localparam logic [15:0] LEDS_WORK        = 16'b1110000000000000;
  localparam logic [15:0] LEDS_BREAK       = 16'b1100000000000000;

  localparam int BTN_CENTER = 0;
  localparam int BTN_UP     = 1;
  localparam int BTN_LEFT   = 2;
  localparam int BTN_RIGHT  = 3;
  localparam int BTN_DOWN   = 4;

  localparam logic [6:0] MINUTES_CLAMP = 7'd99;
  localparam logic [5:0] SECONDS_CLAMP = 6'd59;

  typedef struct packed {
    logic [5:0] def_work;
    logic [4:0] def_break;
    logic [5:0] work_max;
    logic [5:0] work_min;
    logic [4:0] break_max;
    logic [4:0] break_min;
  } cfg_t;

  typedef struct packed {
    logic        cycle_done;
    logic        running;
    logic [15:0] led_pattern;
    logic [3:0]  second_units;
    logic [2:0]  second_tens;
    logic [3:0]  minute_units;
    logic [3:0]  minute_tens;
    logic [3:0]  mode_code;
  } result_t;

  // Split a value of 0..99 into two BCD digits {tens, units}.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [3:0] t;
    logic [6:0] u;
    t = '0;
    for (int i = 1; i < 10; i++) begin
      if (v >= 7'(10 * i)) t = 4'(i);
    end
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

endpackage

/* hdl/work_break_countdown_timer.sv */
// Work/break countdown timer. Each request on the input stream is a button sample
// (in_tuser 0) or a one-second tick (in_tuser 1) and yields exactly one display
// packet on the output stream, in order. A request is taken into an input register,
// the timer state and the packet are updated by one pass of logic, and the packet
// lands in a result register: throughput is one request per clock unless the output
// stalls, and out_tvalid rises once the packet is registered. The input register
// keeps taking a request while a packet waits on a stalled output; a second request
// then waits until the output moves. Configuration writes are meant for idle time;
// new defaults apply at the next restore to setup, new limits at the next press.
module work_break_countdown_timer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // [4:0] buttons (bit0 center, bit1 up, bit2 left, bit3 right, bit4 down), [7:5] zero
  input  logic [7:0]                  in_tdata,
  // [0] func: 0 button sample, 1 one-second tick
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [3:0] mode_code, [7:4] minute_tens, [11:8] minute_units, [14:12] second_tens,
  // [18:15] second_units, [34:19] led_pattern, [35] running, [36] cycle_done,
  // [39:37] zero
  output logic [39:0]                 out_tdata,
  input  logic                        cfg_we,
  input  logic [wbct_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wbct_pkg::CFG_DW-1:0] cfg_wdata
);

  wbct_pkg::cfg_t    cfg;
  wbct_pkg::result_t result;

  logic        in_valid_r;
  logic        in_func_r;
  logic [4:0]  in_btn_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic        advance;
  logic        step;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  wbct_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbct_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .func    (in_func_r),
    .buttons (in_btn_r),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tuser;
      in_btn_r  <= in_tdata[4:0];
    end
    if (step) out_data_r <= {3'b000, result};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* hdl/wbct_cfg_regs.sv */
module wbct_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [wbct_pkg::CFG_IW-1:0] cfg_index,
  input  logic [wbct_pkg::CFG_DW-1:0] cfg_wdata,
  output wbct_pkg::cfg_t              cfg
);

  wbct_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.def_work  <= wbct_pkg::RST_DEF_WORK;
      cfg_r.def_break <= wbct_pkg::RST_DEF_BREAK;
      cfg_r.work_max  <= wbct_pkg::RST_WORK_MAX;
      cfg_r.work_min  <= wbct_pkg::RST_WORK_MIN;
      cfg_r.break_max <= wbct_pkg::RST_BREAK_MAX;
      cfg_r.break_min <= wbct_pkg::RST_BREAK_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        wbct_pkg::CFG_DEF_WORK:  cfg_r.def_work  <= cfg_wdata;
        wbct_pkg::CFG_DEF_BREAK: cfg_r.def_break <= cfg_wdata[4:0];
        wbct_pkg::CFG_WORK_MAX:  cfg_r.work_max  <= cfg_wdata;
        wbct_pkg::CFG_WORK_MIN:  cfg_r.work_min  <= cfg_wdata;
        wbct_pkg::CFG_BREAK_MAX: cfg_r.break_max <= cfg_wdata[4:0];
        wbct_pkg::CFG_BREAK_MIN: cfg_r.break_min <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/wbct_core.sv */
module wbct_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                func,
  input  logic [4:0]          buttons,
  input  wbct_pkg::cfg_t      cfg,
  output wbct_pkg::result_t   result
);

  typedef enum logic [1:0] {
    MODE_SETUP,
    MODE_WORK,
    MODE_BREAK
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [5:0] work_len_r, work_len_nxt;
  logic [4:0] break_len_r, break_len_nxt;
  // remaining time kept as minutes and seconds
  logic [5:0] min_left_r, min_left_nxt;
  logic [5:0] sec_left_r, sec_left_nxt;
  logic [4:0] prev_btn_r, prev_btn_nxt;
  logic       shows_break_r, shows_break_nxt;
  logic [5:0] shown_min_r, shown_min_nxt;
  logic [5:0] shown_sec_r, shown_sec_nxt;
  logic       done;
  logic [4:0] pressed;
  logic [6:0] min_clamped;
  logic [5:0] sec_clamped;
  logic [7:0] min_bcd;
  logic [7:0] sec_bcd;

  assign pressed = buttons & ~prev_btn_r;

  always_comb begin
    mode_nxt        = mode_r;
    work_len_nxt    = work_len_r;
    break_len_nxt   = break_len_r;
    min_left_nxt    = min_left_r;
    sec_left_nxt    = sec_left_r;
    prev_btn_nxt    = prev_btn_r;
    shows_break_nxt = shows_break_r;
    shown_min_nxt   = shown_min_r;
    shown_sec_nxt   = shown_sec_r;
    done            = 1'b0;
    if (step) begin
      if (!func) begin
        prev_btn_nxt = buttons;
        if (mode_r == MODE_SETUP) begin
          // presses resolve in the order up, down, right, left, center
          if (pressed[wbct_pkg::BTN_UP]) begin
            shows_break_nxt = 1'b0;
            if (work_len_nxt < cfg.work_max) work_len_nxt = work_len_nxt + 6'd1;
            shown_min_nxt = work_len_nxt;
            shown_sec_nxt = '0;
          end
          if (pressed[wbct_pkg::BTN_DOWN]) begin
            shows_break_nxt = 1'b0;
            if (work_len_nxt > cfg.work_min) work_len_nxt = work_len_nxt - 6'd1;
            shown_min_nxt = work_len_nxt;
            shown_sec_nxt = '0;
          end
          if (pressed[wbct_pkg::BTN_RIGHT]) begin
            shows_break_nxt = 1'b1;
            if (break_len_nxt < cfg.break_max) break_len_nxt = break_len_nxt + 5'd1;
            shown_min_nxt = {1'b0, break_len_nxt};
            shown_sec_nxt = '0;
          end
          if (pressed[wbct_pkg::BTN_LEFT]) begin
            shows_break_nxt = 1'b1;
            if (break_len_nxt > cfg.break_min) break_len_nxt = break_len_nxt - 5'd1;
            shown_min_nxt = {1'b0, break_len_nxt};
            shown_sec_nxt = '0;
          end
          if (pressed[wbct_pkg::BTN_CENTER]) begin
            mode_nxt     = MODE_WORK;
            min_left_nxt = work_len_nxt;
            sec_left_nxt = '0;
          end
        end
      end else if (mode_r != MODE_SETUP) begin
        // count one second down, stop at zero
        if (sec_left_r != '0) begin
          sec_left_nxt = sec_left_r - 6'd1;
        end else if (min_left_r != '0) begin
          min_left_nxt = min_left_r - 6'd1;
          sec_left_nxt = 6'd59;
        end
        shown_min_nxt = min_left_nxt;
        shown_sec_nxt = sec_left_nxt;
        if (min_left_nxt == '0 && sec_left_nxt == '0) begin
          if (mode_r == MODE_WORK) begin
            mode_nxt      = MODE_BREAK;
            min_left_nxt  = {1'b0, break_len_r};
            sec_left_nxt  = '0;
            shown_min_nxt = {1'b0, break_len_r};
            shown_sec_nxt = '0;
          end else begin
            mode_nxt        = MODE_SETUP;
            min_left_nxt    = '0;
            sec_left_nxt    = '0;
            work_len_nxt    = cfg.def_work;
            break_len_nxt   = cfg.def_break;
            shows_break_nxt = 1'b0;
            shown_min_nxt   = cfg.def_work;
            shown_sec_nxt   = '0;
            done            = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_SETUP;
      work_len_r    <= wbct_pkg::RST_DEF_WORK;
      break_len_r   <= wbct_pkg::RST_DEF_BREAK;
      min_left_r    <= '0;
      sec_left_r    <= '0;
      prev_btn_r    <= '0;
      shows_break_r <= 1'b0;
      shown_min_r   <= wbct_pkg::RST_DEF_WORK;
      shown_sec_r   <= '0;
    end else begin
      mode_r        <= mode_nxt;
      work_len_r    <= work_len_nxt;
      break_len_r   <= break_len_nxt;
      min_left_r    <= min_left_nxt;
      sec_left_r    <= sec_left_nxt;
      prev_btn_r    <= prev_btn_nxt;
      shows_break_r <= shows_break_nxt;
      shown_min_r   <= shown_min_nxt;
      shown_sec_r   <= shown_sec_nxt;
    end
  end

  assign min_clamped = ({1'b0, shown_min_nxt} > wbct_pkg::MINUTES_CLAMP) ?
                       wbct_pkg::MINUTES_CLAMP : {1'b0, shown_min_nxt};
  assign sec_clamped = (shown_sec_nxt > wbct_pkg::SECONDS_CLAMP) ?
                       wbct_pkg::SECONDS_CLAMP : shown_sec_nxt;
  assign min_bcd = wbct_pkg::to_bcd(min_clamped);
  assign sec_bcd = wbct_pkg::to_bcd({1'b0, sec_clamped});

  always_comb begin
    case (mode_nxt)
      MODE_WORK: begin
        result.mode_code   = wbct_pkg::CODE_WORK;
        result.led_pattern = wbct_pkg::LEDS_WORK;
        result.running     = 1'b1;
      end
      MODE_BREAK: begin
        result.mode_code   = wbct_pkg::CODE_BREAK;
        result.led_pattern = wbct_pkg::LEDS_BREAK;
        result.running     = 1'b1;
      end
      default: begin
        result.mode_code   = wbct_pkg::CODE_SETUP;
        result.led_pattern = shows_break_nxt ? wbct_pkg::LEDS_SETUP_BREAK :
                                               wbct_pkg::LEDS_SETUP_WORK;
        result.running     = 1'b0;
      end
    endcase
    result.minute_tens  = min_bcd[7:4];
    result.minute_units = min_bcd[3:0];
    result.second_tens  = sec_bcd[6:4];
    result.second_units = sec_bcd[3:0];
    result.cycle_done   = done;
  end

endmodule

/* hdl/wbct_checker.sv */
`include "work_break_countdown_timer_defines.svh"

module wbct_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [7:0]                  in_tdata,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [39:0]                 out_tdata,
  input logic                        cfg_we,
  input logic [wbct_pkg::CFG_IW-1:0] cfg_index,
  input logic [wbct_pkg::CFG_DW-1:0] cfg_wdata
);

  logic stalled;
  logic in_seen;

  assign stalled = out_tvalid && !out_tready;
  assign in_seen = in_tvalid || in_tready || (|in_tdata) || in_tuser || cfg_we ||
                   (|cfg_index) || (|cfg_wdata);

  // hold a stalled packet
  `WBCT_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable(out_tdata))

  // running flag follows the mode nibble
  `WBCT_ASSERT_NOW(a_running_mode, clk, rst_n, out_tvalid,
                   out_tdata[35] == (out_tdata[3:0] != wbct_pkg::CODE_SETUP))

  // end of a cycle shows setup with the work selection
  `WBCT_ASSERT_NOW(a_done_setup, clk, rst_n, out_tvalid && out_tdata[36],
                   out_tdata[3:0] == wbct_pkg::CODE_SETUP && !out_tdata[35] &&
                   out_tdata[34:19] == wbct_pkg::LEDS_SETUP_WORK &&
                   out_tdata[14:12] == 3'd0 && out_tdata[18:15] == 4'd0)

  // digits stay decimal
  `WBCT_ASSERT_NOW(a_digits, clk, rst_n, out_tvalid || in_seen,
                   !out_tvalid || (out_tdata[7:4] <= 4'd9 && out_tdata[11:8] <= 4'd9 &&
                   out_tdata[14:12] <= 3'd5 && out_tdata[18:15] <= 4'd9))

endmodule

bind work_break_countdown_timer wbct_checker u_wbct_checker (.*);
